### rtl/core/vpp_pkg.sv
// Shared types and helpers for the vertex projection pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package vpp_pkg;

    localparam int DW = 32;

    localparam logic signed [64:0] SAT_MAX = 65'sh0_7FFF_FFFF;
    localparam logic signed [64:0] SAT_MIN = -65'sh0_8000_0000;

    // Values that ride along with the divider lanes.
    typedef struct packed {
        logic signed [DW-1:0] cx;
        logic signed [DW-1:0] cy;
        logic signed [DW-1:0] cz;
        logic signed [DW-1:0] cw;
        logic                 neg_x;
        logic                 neg_y;
        logic                 neg_z;
        logic                 in_view;
        logic                 wzero;
    } side_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [64:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
        return v[DW-1] ? (~v + 32'd1) : v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/vertex_projection_pipeline_unit.sv
// Top level of the vertex projection pipeline: config registers, clip test,
// divider setup and output mapping. Depends on vpp_pkg, vpp_clip, vpp_divider.
//
// One vertex word is accepted every clock cycle while the output is not held, and
// one result word leaves per vertex, in order. The stages are the clip-space
// multiply-add, the magnitude and view-test register, the bit-per-stage divider
// and the output register. The whole pipeline holds while the output word waits.
// When clip w is zero, x and y are mapped undivided, z is the clip z, and the
// w_was_zero flag is set.
`timescale 1ns / 1ps
`default_nettype none
module vertex_projection_pipeline_unit
    import vpp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // in_x, in_y, in_z, in_w
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // out_x, out_y, out_z, out_w, inside_view, w_was_zero
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    localparam int QW = DW + FRAC_BITS;
    localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        REG_SCALE_X  = 4'd0,
        REG_SCALE_Y  = 4'd1,
        REG_SCALE_Z  = 4'd2,
        REG_OFFSET_X = 4'd3,
        REG_OFFSET_Y = 4'd4,
        REG_OFFSET_Z = 4'd5,
        REG_W_FROM_Z = 4'd6,
        REG_W_FROM_W = 4'd7
    } reg_idx_t;

    logic signed [DW-1:0] scale_x_reg, scale_y_reg, scale_z_reg;
    logic signed [DW-1:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic signed [DW-1:0] w_from_z_reg, w_from_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg  <= ONE;
            scale_y_reg  <= ONE;
            scale_z_reg  <= ONE;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            w_from_z_reg <= '0;
            w_from_w_reg <= ONE;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SCALE_X:  scale_x_reg  <= cfg_wdata;
                REG_SCALE_Y:  scale_y_reg  <= cfg_wdata;
                REG_SCALE_Z:  scale_z_reg  <= cfg_wdata;
                REG_OFFSET_X: offset_x_reg <= cfg_wdata;
                REG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                REG_OFFSET_Z: offset_z_reg <= cfg_wdata;
                REG_W_FROM_Z: w_from_z_reg <= cfg_wdata;
                REG_W_FROM_W: w_from_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic                 clip_valid;
    logic signed [DW-1:0] cx, cy, cz, cw;

    vpp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x         (s_tdata[31:0]),
        .y         (s_tdata[63:32]),
        .z         (s_tdata[95:64]),
        .w         (s_tdata[127:96]),
        .scale_x   (scale_x_reg),
        .scale_y   (scale_y_reg),
        .scale_z   (scale_z_reg),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .offset_z  (offset_z_reg),
        .w_from_z  (w_from_z_reg),
        .w_from_w  (w_from_w_reg),
        .out_valid (clip_valid),
        .cx        (cx),
        .cy        (cy),
        .cz        (cz),
        .cw        (cw)
    );

    // Magnitudes, view test and divider operands.
    logic [DW-1:0]          ax, ay, az, aw;
    logic [2:0][DW+QW-1:0]  acc_next;
    side_t                  side_next;
    logic [2:0][DW+QW-1:0]  acc_reg;
    logic [DW-1:0]          dvs_reg;
    side_t                  side_reg;
    logic                   v3_reg;

    always_comb begin
        ax = mag32(cx);
        ay = mag32(cy);
        az = mag32(cz);
        aw = mag32(cw);
        acc_next[0] = {{DW{1'b0}}, QW'(ax) << FRAC_BITS};
        acc_next[1] = {{DW{1'b0}}, QW'(ay) << FRAC_BITS};
        acc_next[2] = {{DW{1'b0}}, QW'(az) << FRAC_BITS};
        side_next.cx      = cx;
        side_next.cy      = cy;
        side_next.cz      = cz;
        side_next.cw      = cw;
        side_next.neg_x   = cx[DW-1] ^ cw[DW-1];
        side_next.neg_y   = cy[DW-1] ^ cw[DW-1];
        side_next.neg_z   = cz[DW-1] ^ cw[DW-1];
        side_next.in_view = (ax <= aw) && (ay <= aw) && (az <= aw);
        side_next.wzero   = (cw == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= clip_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg  <= acc_next;
            dvs_reg  <= aw;
            side_reg <= side_next;
        end
    end

    logic              div_valid;
    logic [2:0][QW-1:0] quo;
    side_t             div_side;

    vpp_divider #(.QW(QW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_acc    (acc_reg),
        .in_dvs    (dvs_reg),
        .in_side   (side_reg),
        .out_valid (div_valid),
        .out_quo   (quo),
        .out_side  (div_side)
    );

    // Sign, saturation, zero-w bypass and the 0..1 mapping of x and y.
    logic [2:0]               negs;
    logic signed [2:0][DW-1:0] qs;
    logic signed [DW-1:0]     dx, dy, dz;
    logic signed [DW:0]       mx, my;
    logic [135:0]             data_next;
    logic [135:0]             data_reg;

    always_comb begin
        negs = {div_side.neg_z, div_side.neg_y, div_side.neg_x};
        for (int l = 0; l < 3; l++) begin
            if (!negs[l]) begin
                qs[l] = (quo[l] > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[l][DW-1:0];
            end else begin
                qs[l] = (quo[l] > QW'(32'h8000_0000)) ? 32'h8000_0000
                                                      : DW'(~quo[l] + QW'(1));
            end
        end
        dx = div_side.wzero ? div_side.cx : qs[0];
        dy = div_side.wzero ? div_side.cy : qs[1];
        dz = div_side.wzero ? div_side.cz : qs[2];
        mx = {dx[DW-1], dx} + (DW+1)'(ONE);
        my = {dy[DW-1], dy} + (DW+1)'(ONE);
        data_next = {6'd0, div_side.wzero, div_side.in_view, div_side.cw, dz,
                     my[DW:1], mx[DW:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

### rtl/core/vpp_clip.sv
// Clip-space transform: eight registered products, then sum, floor shift and saturate.
// Depends on vpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpp_clip
    import vpp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [DW-1:0] x,
    input  wire logic signed [DW-1:0] y,
    input  wire logic signed [DW-1:0] z,
    input  wire logic signed [DW-1:0] w,
    input  wire logic signed [DW-1:0] scale_x,
    input  wire logic signed [DW-1:0] scale_y,
    input  wire logic signed [DW-1:0] scale_z,
    input  wire logic signed [DW-1:0] offset_x,
    input  wire logic signed [DW-1:0] offset_y,
    input  wire logic signed [DW-1:0] offset_z,
    input  wire logic signed [DW-1:0] w_from_z,
    input  wire logic signed [DW-1:0] w_from_w,
    output logic                      out_valid,
    output logic signed [DW-1:0]      cx,
    output logic signed [DW-1:0]      cy,
    output logic signed [DW-1:0]      cz,
    output logic signed [DW-1:0]      cw
);

    logic signed [63:0] prod_reg [8];
    logic               v1_reg;
    logic               v2_reg;
    logic signed [DW-1:0] c_reg [4];
    logic signed [64:0] sum_next [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= x * scale_x;
            prod_reg[1] <= w * offset_x;
            prod_reg[2] <= y * scale_y;
            prod_reg[3] <= w * offset_y;
            prod_reg[4] <= z * scale_z;
            prod_reg[5] <= w * offset_z;
            prod_reg[6] <= z * w_from_z;
            prod_reg[7] <= w * w_from_w;
        end
    end

    // The exact sum shifted arithmetically gives the floor.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum_next[i] = ($signed({prod_reg[2*i][63], prod_reg[2*i]})
                         + $signed({prod_reg[2*i+1][63], prod_reg[2*i+1]})) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                c_reg[i] <= sat32(sum_next[i]);
            end
        end
    end

    assign out_valid = v2_reg;
    assign cx = c_reg[0];
    assign cy = c_reg[1];
    assign cz = c_reg[2];
    assign cw = c_reg[3];

endmodule
`default_nettype wire

### rtl/core/vpp_divider.sv
// Three-lane restoring divider, one quotient bit per pipeline stage.
// Depends on vpp_pkg for the sideband struct.
`timescale 1ns / 1ps
`default_nettype none
module vpp_divider
    import vpp_pkg::*;
#(
    parameter int QW = 48
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [2:0][DW+QW-1:0]   in_acc,
    input  wire logic [DW-1:0]           in_dvs,
    input  wire side_t                   in_side,
    output logic                         out_valid,
    output logic [2:0][QW-1:0]           out_quo,
    output side_t                        out_side
);

    localparam int AW = DW + QW;

    logic [2:0][AW-1:0] acc_reg  [QW];
    logic [DW-1:0]      dvs_reg  [QW];
    side_t              side_reg [QW];
    logic               vld_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [2:0][AW-1:0] acc_in;
        logic [DW-1:0]      dvs_in;
        side_t              side_in;
        logic               vld_in;
        logic [2:0][AW-1:0] acc_next;

        if (k == 0) begin : g_first
            assign acc_in  = in_acc;
            assign dvs_in  = in_dvs;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign acc_in  = acc_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // Upper DW bits hold the remainder; the next dividend bit sits just below.
        always_comb begin
            logic [DW:0] t;
            logic [DW:0] d;
            for (int l = 0; l < 3; l++) begin
                t = acc_in[l][AW-1:QW-1];
                d = {1'b0, dvs_in};
                if (t >= d) begin
                    acc_next[l] = {DW'(t - d), acc_in[l][QW-2:0], 1'b1};
                end else begin
                    acc_next[l] = {t[DW-1:0], acc_in[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k]  <= acc_next;
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            out_quo[l] = acc_reg[QW-1][l][QW-1:0];
        end
    end

endmodule
`default_nettype wire
